// ===== hw/rtl/kms_pkg.sv =====
// kms_pkg: shared widths, constants and controller/datapath interface types
// for the k-mer minimizer selector. No dependencies.
`timescale 1ns / 1ps

package kms_pkg;

	// window depth in k-mers
	localparam int WINDOW_MAX = 16;

	// widths that follow from the window depth
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	// fixed field widths
	localparam int KMER_W    = 64;
	localparam int KLEN_W    = 6;
	localparam int WLEN_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;
	localparam int BASE_W    = 2;

	// longest k-mer in bases
	localparam logic [KLEN_W-1:0] KMER_MAX = 6'd32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

	// controller to datapath
	typedef struct packed {
		logic step;    // take the accepted base into the run state
		logic load;    // start the window scan at the oldest entry
		logic scan;    // compare one more window entry
		logic commit;  // write the result and finish the item
	} kms_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic win_needed;  // this item completes a full window
		logic scan_done;   // no entries left to compare
		logic res_valid;   // the item yields a result
		logic out_free;    // output register can take a result
	} kms_stat_t;

endpackage

// ===== hw/rtl/kms_ctrl.sv =====
// kms_ctrl: sequencing state machine of the k-mer minimizer selector.
// Depends on kms_pkg for the command and status types.
`timescale 1ns / 1ps

module kms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kms_pkg::kms_stat_t stat,
	output kms_pkg::kms_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.step = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.win_needed) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_DECIDE: begin
				// hold while a result waits for the output register
				if (!stat.res_valid || stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/kms_datapath.sv =====
// kms_datapath: rolling k-mer, run counters, window shift line, min scan
// and output register. Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kms_pkg::kms_cmd_t               cmd,
	output kms_pkg::kms_stat_t              stat,
	input  logic [kms_pkg::KLEN_W-1:0]      k_eff,
	input  logic [kms_pkg::CNT_W-1:0]       w_eff,
	input  logic [kms_pkg::BASE_W-1:0]      base_code,
	input  logic                            base_invalid,
	input  logic                            region_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [kms_pkg::KMER_W-1:0]      kmer_value,
	output logic                            short_run_pick
);

	localparam logic [kms_pkg::CNT_W-1:0] WIN_NONE = kms_pkg::CNT_W'(kms_pkg::WINDOW_MAX);

	logic [kms_pkg::KMER_W-1:0] rolling_q;
	logic [kms_pkg::KLEN_W-1:0] vrl_q;
	logic [kms_pkg::CNT_W-1:0]  count_q;
	logic [kms_pkg::CNT_W-1:0]  age_q;
	logic [kms_pkg::KMER_W-1:0] short_min_q;
	logic [kms_pkg::KMER_W-1:0] store_q [kms_pkg::WINDOW_MAX];
	logic                       win_needed_q;
	logic                       close_q;
	logic [kms_pkg::IDX_W-1:0]  best_q;
	logic [kms_pkg::IDX_W-1:0]  j_q;
	logic [kms_pkg::KMER_W-1:0] bv_q;
	logic                       out_valid_q;
	logic [kms_pkg::KMER_W-1:0] kmer_value_q;
	logic                       short_pick_q;

	logic [kms_pkg::KMER_W-1:0] mask;
	logic [kms_pkg::KMER_W-1:0] rolling_n;
	logic [kms_pkg::KLEN_W-1:0] vrl_n;
	logic [kms_pkg::CNT_W-1:0]  count_n;
	logic                       kmer_made;
	logic [kms_pkg::CNT_W-1:0]  wm1;
	logic [kms_pkg::IDX_W-1:0]  j_n;
	logic                       pick_ok;
	logic                       short_ok;
	logic [kms_pkg::KMER_W-1:0] res_value;

	// new k-mer from the accepted base
	always_comb begin
		if (k_eff >= kms_pkg::KMER_MAX) begin
			mask = '1;
		end else begin
			mask = ~({kms_pkg::KMER_W{1'b1}} << {k_eff, 1'b0});
		end
		rolling_n = ({rolling_q[kms_pkg::KMER_W-3:0], base_code}) & mask;
		vrl_n     = (vrl_q < kms_pkg::KMER_MAX) ? vrl_q + 1'b1 : vrl_q;
		count_n   = (count_q < WIN_NONE) ? count_q + 1'b1 : count_q;
		kmer_made = !base_invalid && (vrl_n >= k_eff);
	end

	assign wm1 = w_eff - 1'b1;
	assign j_n = j_q - 1'b1;

	// end-of-item decision
	assign pick_ok   = win_needed_q && ({1'b0, best_q} != age_q);
	assign short_ok  = close_q && (count_q != '0) && (count_q < w_eff);
	assign res_value = pick_ok ? bv_q : short_min_q;

	assign stat.win_needed = win_needed_q;
	assign stat.scan_done  = (j_q == '0);
	assign stat.res_valid  = pick_ok || short_ok;
	assign stat.out_free   = !out_valid_q || out_ready;

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rolling_q    <= '0;
			vrl_q        <= '0;
			count_q      <= '0;
			age_q        <= WIN_NONE;
			short_min_q  <= '1;
			win_needed_q <= 1'b0;
			close_q      <= 1'b0;
		end else if (cmd.step) begin
			close_q      <= base_invalid || region_last;
			win_needed_q <= kmer_made && (count_n >= w_eff);
			if (!base_invalid) begin
				rolling_q <= rolling_n;
				vrl_q     <= vrl_n;
			end
			if (kmer_made) begin
				count_q <= count_n;
				if (rolling_n < short_min_q) begin
					short_min_q <= rolling_n;
				end
				if (age_q < WIN_NONE) begin
					age_q <= age_q + 1'b1;
				end
			end
		end else if (cmd.commit) begin
			if (close_q) begin
				rolling_q   <= '0;
				vrl_q       <= '0;
				count_q     <= '0;
				age_q       <= WIN_NONE;
				short_min_q <= '1;
			end else if (pick_ok) begin
				age_q <= {1'b0, best_q};
			end
		end
	end

	// window shift line, newest at entry 0
	always_ff @(posedge clk) begin
		if (cmd.step && kmer_made) begin
			for (int i = kms_pkg::WINDOW_MAX - 1; i > 0; i--) begin
				store_q[i] <= store_q[i-1];
			end
			store_q[0] <= rolling_n;
		end
	end

	// minimum scan, oldest first, strict compare keeps the oldest on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else if (cmd.load) begin
			j_q <= wm1[kms_pkg::IDX_W-1:0];
		end else if (cmd.scan) begin
			j_q <= j_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_q <= wm1[kms_pkg::IDX_W-1:0];
			bv_q   <= store_q[wm1[kms_pkg::IDX_W-1:0]];
		end else if (cmd.scan && (store_q[j_n] < bv_q)) begin
			best_q <= j_n;
			bv_q   <= store_q[j_n];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && stat.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && stat.res_valid) begin
			kmer_value_q <= res_value;
			short_pick_q <= !pick_ok;
		end
	end

	assign out_valid      = out_valid_q;
	assign kmer_value     = kmer_value_q;
	assign short_run_pick = short_pick_q;

endmodule

// ===== hw/rtl/kmer_minimizer_selector.sv =====
// kmer_minimizer_selector: top level with configuration registers,
// sequencing controller and datapath. Depends on kms_pkg, kms_ctrl, kms_datapath.
`timescale 1ns / 1ps

//  channel   signals                                    direction  request
//  -------   -----------------------------------------  ---------  ---------------
//  input     in_valid/in_ready, base_code,              in         one base
//            base_invalid, region_last
//  output    out_valid/out_ready, kmer_value,           out        one picked k-mer
//            short_run_pick
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data   in         one register write
//
//  a base that completes no full window goes from idle through load to decide; one that
//    does also passes the scan state, a one-entry-per-cycle minimum scan over the
//    clamped window length of the window shift line
//  one base is in flight at a time; in_ready is high only when the controller idles
//  a result waits in the output register; the next base is taken meanwhile, and the
//    controller stalls only when a second result meets a full output register
//  reset clears the run state, the counters and the output valid; the window line
//    needs no clearing since only entries written in the current run are read

module kmer_minimizer_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	// base input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kms_pkg::BASE_W-1:0]         base_code,
	input  logic                               base_invalid,
	input  logic                               region_last,
	// picked k-mers
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kms_pkg::KMER_W-1:0]         kmer_value,
	output logic                               short_run_pick,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kms_pkg::CFG_DAT_W-1:0]      cfg_data
);

	logic [kms_pkg::KLEN_W-1:0] kmer_length_q;
	logic [kms_pkg::WLEN_W-1:0] window_length_q;
	logic [kms_pkg::KLEN_W-1:0] k_eff;
	logic [kms_pkg::CNT_W-1:0]  w_eff;
	kms_pkg::kms_cmd_t          cmd;
	kms_pkg::kms_stat_t         stat;

	// each write goes straight into its register, so the port never pushes back
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q   <= 6'd31;
			window_length_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				kms_pkg::CFG_KMER_LENGTH: begin
					kmer_length_q <= cfg_data;
				end
				kms_pkg::CFG_WINDOW_LENGTH: begin
					window_length_q <= cfg_data[kms_pkg::WLEN_W-1:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// clamp k to 1..32
	always_comb begin
		if (kmer_length_q == '0) begin
			k_eff = 6'd1;
		end else if (kmer_length_q > kms_pkg::KMER_MAX) begin
			k_eff = kms_pkg::KMER_MAX;
		end else begin
			k_eff = kmer_length_q;
		end
	end

	// clamp window to 1..window depth
	always_comb begin
		if (window_length_q == '0) begin
			w_eff = kms_pkg::CNT_W'(1);
		end else if (32'(window_length_q) > 32'(kms_pkg::WINDOW_MAX)) begin
			w_eff = kms_pkg::CNT_W'(kms_pkg::WINDOW_MAX);
		end else begin
			w_eff = kms_pkg::CNT_W'(window_length_q);
		end
	end

	kms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kms_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.k_eff          (k_eff),
		.w_eff          (w_eff),
		.base_code      (base_code),
		.base_invalid   (base_invalid),
		.region_last    (region_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kmer_value     (kmer_value),
		.short_run_pick (short_run_pick)
	);

	// controller issues at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.step, cmd.load, cmd.scan, cmd.commit}))
		else $error("more than one datapath command");

	// one base in flight: no request taken in the cycle after one is taken
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second base taken while one is in flight");

	// a result is only written when the output register can hold it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stat.res_valid) |-> stat.out_free)
		else $error("result written over a pending one");

	// a committed result shows up at the output next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && stat.res_valid) |=> out_valid)
		else $error("committed result not presented");

endmodule
